/* hdl/lda_addressing_sequencer_core_macros.svh */
// assertion macros shared by the rtl
`ifndef LDA_ADDRESSING_SEQUENCER_CORE_MACROS_SVH
`define LDA_ADDRESSING_SEQUENCER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge outside reset
`define LDA_ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lda sequencer check failed");

// condition that must never hold outside reset
`define LDA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lda sequencer forbidden condition");

`else

`define LDA_ASSERT_PROP(lbl, prop)
`define LDA_ASSERT_NEVER(lbl, cond)

`endif

`endif

/* hdl/lda_pkg.sv */
package lda_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_OP1   = 3'd1,
        PH_OP2   = 3'd2,
        PH_PLO   = 3'd3,
        PH_PHI   = 3'd4,
        PH_FINAL = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        AM_IMM  = 3'd0,
        AM_ZP   = 3'd1,
        AM_ZPX  = 3'd2,
        AM_ABS  = 3'd3,
        AM_ABSX = 3'd4,
        AM_ABSY = 3'd5,
        AM_INDX = 3'd6,
        AM_INDY = 3'd7
    } addr_mode_t;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_BAD_OP  = 2'd2,
        KIND_STRAY   = 2'd3
    } kind_t;

    localparam logic MODE_START = 1'b0;

    localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
    localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
    localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
    localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
    localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
    localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
    localparam logic [7:0] OP_LDA_INDX = 8'hA1;
    localparam logic [7:0] OP_LDA_INDY = 8'hB1;

    function automatic logic [2:0] base_cycles(input addr_mode_t m);
        logic [2:0] c;
        unique case (m)
            AM_IMM:  c = 3'd2;
            AM_ZP:   c = 3'd3;
            AM_INDX: c = 3'd6;
            AM_INDY: c = 3'd5;
            default: c = 3'd4;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] operand_len(input addr_mode_t m);
        logic [1:0] n;
        unique case (m)
            AM_ABS, AM_ABSX, AM_ABSY: n = 2'd2;
            default:                  n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

/* hdl/lda_addressing_sequencer_core.sv */
// LDA addressing sequencer: runs the 6502 load-accumulator instruction in its
// eight addressing modes (immediate, zp, zp,X, abs, abs,X, abs,Y, (zp,X),
// (zp),Y), one bus byte per item. A start item (tuser 0) brings opcode, PC,
// X and Y; each data item (tuser 1) returns the byte for the previous read
// request. Every item gives exactly one result: a read request, a finished
// load with flags, cycle count and next PC, an unsupported opcode, or a stray
// data item seen while idle. Zero-page indexing and pointer fetches wrap in
// page zero. A start item aborts any instruction in progress. The block takes
// one item per clock; its result appears in the output register the cycle
// after acceptance, and a new item is taken whenever that register is empty
// or being drained in the same cycle.
`include "lda_addressing_sequencer_core_macros.svh"

module lda_addressing_sequencer_core
    import lda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode, start_pc, index_x, index_y, read_data
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // bus_address, acc_value, zero_flag, negative_flag,
                                   // cycle_count, next_pc, zero padding
    output logic [1:0]  m_tuser    // kind
);

    logic [7:0]  in_opcode;
    logic [15:0] in_start_pc;
    logic [7:0]  in_x;
    logic [7:0]  in_y;
    logic [7:0]  in_data;
    logic        in_accept;

    phase_t      phase_reg, phase_next;
    addr_mode_t  addr_mode_reg, addr_mode_next;
    logic [15:0] saved_pc_reg, saved_pc_next;
    logic [7:0]  saved_x_reg, saved_x_next;
    logic [7:0]  saved_y_reg, saved_y_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic [15:0] work_address_reg, work_address_next;
    logic        page_crossed_reg, page_crossed_next;

    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [15:0] bus_address_reg, bus_address_next;
    logic [7:0]  acc_reg, acc_next;
    logic        zero_reg, zero_next;
    logic        neg_reg, neg_next;
    logic [2:0]  cycles_reg, cycles_next;
    logic [15:0] next_pc_reg, next_pc_next;

    logic        finish;
    logic [15:0] full_addr;
    logic [7:0]  index_sel;
    logic [15:0] indexed_addr;
    addr_mode_t  decoded_mode;
    logic        decode_ok;

    assign in_opcode   = s_tdata[7:0];
    assign in_start_pc = s_tdata[23:8];
    assign in_x        = s_tdata[31:24];
    assign in_y        = s_tdata[39:32];
    assign in_data     = s_tdata[47:40];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // pointer or operand high byte joined with the saved low byte
    assign full_addr    = {in_data, low_byte_reg};
    assign index_sel    = (addr_mode_reg == AM_ABSX) ? saved_x_reg : saved_y_reg;
    assign indexed_addr = full_addr + {8'd0, index_sel};

    always_comb
    begin
        decode_ok    = 1'b1;
        decoded_mode = AM_IMM;
        unique case (in_opcode)
            OP_LDA_IMM:  decoded_mode = AM_IMM;
            OP_LDA_ZP:   decoded_mode = AM_ZP;
            OP_LDA_ZPX:  decoded_mode = AM_ZPX;
            OP_LDA_ABS:  decoded_mode = AM_ABS;
            OP_LDA_ABSX: decoded_mode = AM_ABSX;
            OP_LDA_ABSY: decoded_mode = AM_ABSY;
            OP_LDA_INDX: decoded_mode = AM_INDX;
            OP_LDA_INDY: decoded_mode = AM_INDY;
            default:     decode_ok    = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        addr_mode_next    = addr_mode_reg;
        saved_pc_next     = saved_pc_reg;
        saved_x_next      = saved_x_reg;
        saved_y_next      = saved_y_reg;
        low_byte_next     = low_byte_reg;
        work_address_next = work_address_reg;
        page_crossed_next = page_crossed_reg;
        kind_next         = KIND_READ;
        bus_address_next  = 16'd0;
        finish            = 1'b0;

        if (s_tuser[0] == MODE_START)
        begin
            if (!decode_ok)
            begin
                phase_next = PH_IDLE;
                kind_next  = KIND_BAD_OP;
            end
            else
            begin
                addr_mode_next    = decoded_mode;
                saved_pc_next     = in_start_pc;
                saved_x_next      = in_x;
                saved_y_next      = in_y;
                low_byte_next     = 8'd0;
                work_address_next = 16'd0;
                page_crossed_next = 1'b0;
                bus_address_next  = in_start_pc;
                phase_next        = PH_OP1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_OP1:
                begin
                    unique case (addr_mode_reg)
                        AM_IMM:
                            finish = 1'b1;
                        AM_ZP:
                        begin
                            work_address_next = {8'd0, in_data};
                            bus_address_next  = {8'd0, in_data};
                            phase_next        = PH_FINAL;
                        end
                        AM_ZPX:
                        begin
                            work_address_next = {8'd0, in_data + saved_x_reg};
                            bus_address_next  = {8'd0, in_data + saved_x_reg};
                            phase_next        = PH_FINAL;
                        end
                        AM_INDX:
                        begin
                            work_address_next = {8'd0, in_data + saved_x_reg};
                            bus_address_next  = {8'd0, in_data + saved_x_reg};
                            phase_next        = PH_PLO;
                        end
                        AM_INDY:
                        begin
                            work_address_next = {8'd0, in_data};
                            bus_address_next  = {8'd0, in_data};
                            phase_next        = PH_PLO;
                        end
                        default:
                        begin
                            low_byte_next    = in_data;
                            bus_address_next = saved_pc_reg + 16'd1;
                            phase_next       = PH_OP2;
                        end
                    endcase
                end
                PH_OP2, PH_PHI:
                begin
                    if (addr_mode_reg == AM_ABSX || addr_mode_reg == AM_ABSY ||
                        addr_mode_reg == AM_INDY)
                    begin
                        work_address_next = indexed_addr;
                        page_crossed_next = indexed_addr[15:8] != full_addr[15:8];
                        bus_address_next  = indexed_addr;
                    end
                    else
                    begin
                        work_address_next = full_addr;
                        bus_address_next  = full_addr;
                    end
                    phase_next = PH_FINAL;
                end
                PH_PLO:
                begin
                    // high pointer byte wraps within page zero
                    low_byte_next    = in_data;
                    bus_address_next = {8'd0, work_address_reg[7:0] + 8'd1};
                    phase_next       = PH_PHI;
                end
                PH_FINAL:
                    finish = 1'b1;
                default:
                    kind_next = KIND_STRAY;
            endcase
        end

        if (finish)
        begin
            kind_next  = KIND_DONE;
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        acc_next     = 8'd0;
        zero_next    = 1'b0;
        neg_next     = 1'b0;
        cycles_next  = 3'd0;
        next_pc_next = 16'd0;
        if (finish)
        begin
            acc_next     = in_data;
            zero_next    = in_data == 8'd0;
            neg_next     = in_data[7];
            cycles_next  = base_cycles(addr_mode_reg) + {2'd0, page_crossed_reg};
            next_pc_next = saved_pc_reg + {14'd0, operand_len(addr_mode_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            addr_mode_reg    <= AM_IMM;
            saved_pc_reg     <= 16'd0;
            saved_x_reg      <= 8'd0;
            saved_y_reg      <= 8'd0;
            low_byte_reg     <= 8'd0;
            work_address_reg <= 16'd0;
            page_crossed_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                out_valid_reg <= s_tvalid;
            end
            if (in_accept)
            begin
                phase_reg        <= phase_next;
                addr_mode_reg    <= addr_mode_next;
                saved_pc_reg     <= saved_pc_next;
                saved_x_reg      <= saved_x_next;
                saved_y_reg      <= saved_y_next;
                low_byte_reg     <= low_byte_next;
                work_address_reg <= work_address_next;
                page_crossed_reg <= page_crossed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg        <= kind_next;
            bus_address_reg <= bus_address_next;
            acc_reg         <= acc_next;
            zero_reg        <= zero_next;
            neg_reg         <= neg_next;
            cycles_reg      <= cycles_next;
            next_pc_reg     <= next_pc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'd0, next_pc_reg, cycles_reg, neg_reg, zero_reg,
                       acc_reg, bus_address_reg};

    // finished loads report a plausible cycle count
    `LDA_ASSERT_PROP(a_done_cycles,
        (out_valid_reg && kind_reg == KIND_DONE) |-> (cycles_reg >= 3'd2 && cycles_reg <= 3'd6))
    // zero flag agrees with the loaded value
    `LDA_ASSERT_PROP(a_zero_flag,
        (out_valid_reg && kind_reg == KIND_DONE) |-> (zero_reg == (acc_reg == 8'd0)))
    // a finished or rejected instruction leaves the sequencer idle
    `LDA_ASSERT_PROP(a_idle_after_end,
        (in_accept && (kind_next == KIND_DONE || kind_next == KIND_BAD_OP))
            |=> (phase_reg == PH_IDLE))
    // page penalty only in indexed modes that can cross
    `LDA_ASSERT_NEVER(a_page_mode,
        page_crossed_reg && addr_mode_reg != AM_ABSX && addr_mode_reg != AM_ABSY &&
        addr_mode_reg != AM_INDY)
    // pointer fetch phases only in indirect modes
    `LDA_ASSERT_NEVER(a_ptr_mode,
        (phase_reg == PH_PLO || phase_reg == PH_PHI) &&
        addr_mode_reg != AM_INDX && addr_mode_reg != AM_INDY)

endmodule

/* tb/lda_sequencer_checker.sv */
`timescale 1ns / 100ps

module lda_sequencer_checker
    import lda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode, start_pc, index_x, index_y, read_data
    input  logic [0:0]  s_tuser,   // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // bus_address, acc_value, zero_flag, negative_flag,
                                   // cycle_count, next_pc, zero padding
    input  logic [1:0]  m_tuser,   // kind
    output int unsigned errors,
    output int unsigned outstanding
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] bus_address;
        logic [7:0]  acc_value;
        logic        zero_flag;
        logic        negative_flag;
        logic [2:0]  cycle_count;
        logic [15:0] next_pc;
    } lda_result_t;

    lda_result_t pending_lda_results[$];

    // shadow copy of the sequencer state
    phase_t      seq_phase;
    addr_mode_t  seq_mode;
    logic [15:0] seq_pc;
    logic [7:0]  seq_x;
    logic [7:0]  seq_y;
    logic [7:0]  seq_low;
    logic [15:0] seq_addr;
    logic        seq_crossed;

    int unsigned errors_q = 0;
    int unsigned outstanding_q = 0;
    lda_result_t want_r;
    lda_result_t got_r;
    lda_result_t next_r;

    assign errors      = errors_q;
    assign outstanding = outstanding_q;

    function automatic logic [2:0] lda_cycles(input addr_mode_t m);
        case (m)
            AM_IMM:  return 3'd2;
            AM_ZP:   return 3'd3;
            AM_INDX: return 3'd6;
            AM_INDY: return 3'd5;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic [15:0] lda_operand_bytes(input addr_mode_t m);
        if (m == AM_ABS || m == AM_ABSX || m == AM_ABSY)
            return 16'd2;
        return 16'd1;
    endfunction

    task automatic add_index(input logic [15:0] base, input logic [7:0] idx);
        seq_addr    = base + {8'h00, idx};
        seq_crossed = (seq_addr[15:8] != base[15:8]);
    endtask

    task automatic finish_load(inout lda_result_t r, input logic [7:0] v);
        r.kind          = KIND_DONE;
        r.acc_value     = v;
        r.zero_flag     = (v == 8'h00);
        r.negative_flag = v[7];
        r.cycle_count   = lda_cycles(seq_mode) + {2'b00, seq_crossed};
        r.next_pc       = seq_pc + lda_operand_bytes(seq_mode);
        seq_phase       = PH_IDLE;
    endtask

    // advances the shadow state by one item and gives the result it causes
    task automatic step_lda_sequence(input logic mode, input logic [47:0] d,
                                     output lda_result_t r);
        logic [7:0]  op;
        logic [7:0]  rd;
        logic [15:0] full;
        addr_mode_t  m;
        logic        known;
        op    = d[7:0];
        rd    = d[47:40];
        r     = '0;
        r.kind = KIND_READ;
        if (mode == MODE_START)
        begin
            known = 1'b1;
            m     = AM_IMM;
            case (op)
                OP_LDA_IMM:  m = AM_IMM;
                OP_LDA_ZP:   m = AM_ZP;
                OP_LDA_ZPX:  m = AM_ZPX;
                OP_LDA_ABS:  m = AM_ABS;
                OP_LDA_ABSX: m = AM_ABSX;
                OP_LDA_ABSY: m = AM_ABSY;
                OP_LDA_INDX: m = AM_INDX;
                OP_LDA_INDY: m = AM_INDY;
                default:     known = 1'b0;
            endcase
            if (!known)
            begin
                seq_phase = PH_IDLE;
                r.kind    = KIND_BAD_OP;
            end
            else
            begin
                seq_mode      = m;
                seq_pc        = d[23:8];
                seq_x         = d[31:24];
                seq_y         = d[39:32];
                seq_low       = 8'h00;
                seq_addr      = 16'h0000;
                seq_crossed   = 1'b0;
                r.bus_address = seq_pc;
                seq_phase     = PH_OP1;
            end
        end
        else
        begin
            case (seq_phase)
                PH_OP1:
                begin
                    case (seq_mode)
                        AM_IMM:
                            finish_load(r, rd);
                        AM_ZP:
                        begin
                            seq_addr      = {8'h00, rd};
                            r.bus_address = seq_addr;
                            seq_phase     = PH_FINAL;
                        end
                        AM_ZPX:
                        begin
                            // index wraps inside page zero
                            seq_addr      = {8'h00, 8'(rd + seq_x)};
                            r.bus_address = seq_addr;
                            seq_phase     = PH_FINAL;
                        end
                        AM_INDX:
                        begin
                            seq_addr      = {8'h00, 8'(rd + seq_x)};
                            r.bus_address = seq_addr;
                            seq_phase     = PH_PLO;
                        end
                        AM_INDY:
                        begin
                            seq_addr      = {8'h00, rd};
                            r.bus_address = seq_addr;
                            seq_phase     = PH_PLO;
                        end
                        default:
                        begin
                            seq_low       = rd;
                            r.bus_address = seq_pc + 16'd1;
                            seq_phase     = PH_OP2;
                        end
                    endcase
                end
                PH_OP2:
                begin
                    full = {rd, seq_low};
                    if (seq_mode == AM_ABSX)
                        add_index(full, seq_x);
                    else if (seq_mode == AM_ABSY)
                        add_index(full, seq_y);
                    else
                        seq_addr = full;
                    r.bus_address = seq_addr;
                    seq_phase     = PH_FINAL;
                end
                PH_PLO:
                begin
                    // pointer high byte also stays in page zero
                    seq_low       = rd;
                    r.bus_address = {8'h00, 8'(seq_addr[7:0] + 8'd1)};
                    seq_phase     = PH_PHI;
                end
                PH_PHI:
                begin
                    full = {rd, seq_low};
                    if (seq_mode == AM_INDY)
                        add_index(full, seq_y);
                    else
                        seq_addr = full;
                    r.bus_address = seq_addr;
                    seq_phase     = PH_FINAL;
                end
                PH_FINAL:
                    finish_load(r, rd);
                default:
                    r.kind = KIND_STRAY;
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors_q++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_phase   = PH_IDLE;
            seq_mode    = AM_IMM;
            seq_pc      = 16'h0000;
            seq_x       = 8'h00;
            seq_y       = 8'h00;
            seq_low     = 8'h00;
            seq_addr    = 16'h0000;
            seq_crossed = 1'b0;
            pending_lda_results.delete();
            outstanding_q = 0;
        end
        else
        begin
            // a result leaving now belongs to an older item than one entering now
            if (m_tvalid && m_tready)
            begin
                got_r.kind          = m_tuser;
                got_r.bus_address   = m_tdata[15:0];
                got_r.acc_value     = m_tdata[23:16];
                got_r.zero_flag     = m_tdata[24];
                got_r.negative_flag = m_tdata[25];
                got_r.cycle_count   = m_tdata[28:26];
                got_r.next_pc       = m_tdata[44:29];
                if (pending_lda_results.size() == 0)
                begin
                    $error("result with no item pending: kind %0d, data 0x%0h",
                           m_tuser, m_tdata);
                    errors_q++;
                end
                else
                begin
                    want_r = pending_lda_results.pop_front();
                    check_field("kind", {14'h0, want_r.kind}, {14'h0, got_r.kind});
                    check_field("bus_address", want_r.bus_address, got_r.bus_address);
                    check_field("acc_value", {8'h00, want_r.acc_value},
                                {8'h00, got_r.acc_value});
                    check_field("zero_flag", {15'h0, want_r.zero_flag},
                                {15'h0, got_r.zero_flag});
                    check_field("negative_flag", {15'h0, want_r.negative_flag},
                                {15'h0, got_r.negative_flag});
                    check_field("cycle_count", {13'h0, want_r.cycle_count},
                                {13'h0, got_r.cycle_count});
                    check_field("next_pc", want_r.next_pc, got_r.next_pc);
                end
            end
            if (s_tvalid && s_tready)
            begin
                step_lda_sequence(s_tuser[0], s_tdata, next_r);
                pending_lda_results.push_back(next_r);
            end
            outstanding_q = pending_lda_results.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import lda_pkg::*;

    localparam int ITEM_TARGET    = 780;
    localparam int HOLD_AT        = 300;
    localparam int DRAIN_AT       = 560;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    int unsigned errors;
    int unsigned outstanding;

    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_loads = 0;
    int unsigned n_aborted = 0;
    int unsigned n_bad_op = 0;
    int unsigned n_stray = 0;
    int unsigned n_holds = 0;
    logic        hold_req = 1'b0;

    always #6 clk = ~clk;

    lda_addressing_sequencer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lda_sequencer_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned data_bytes(input logic [7:0] op);
        case (op)
            OP_LDA_IMM:                           return 1;
            OP_LDA_ZP, OP_LDA_ZPX:                return 2;
            OP_LDA_ABS, OP_LDA_ABSX, OP_LDA_ABSY: return 3;
            OP_LDA_INDX, OP_LDA_INDY:             return 4;
            default:                              return 0;
        endcase
    endfunction

    function automatic logic [7:0] pick_lda_op();
        case ($urandom_range(0, 7))
            0:       return OP_LDA_IMM;
            1:       return OP_LDA_ZP;
            2:       return OP_LDA_ZPX;
            3:       return OP_LDA_ABS;
            4:       return OP_LDA_ABSX;
            5:       return OP_LDA_ABSY;
            6:       return OP_LDA_INDX;
            default: return OP_LDA_INDY;
        endcase
    endfunction

    function automatic logic [15:0] pick_pc();
        if ($urandom_range(0, 99) >= 15)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'hFFFF;
            1:       return 16'hFFFE;
            2:       return 16'h0000;
            default: return 16'h00FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 99) >= 20)
            return 8'($urandom);
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_item(input logic mode, input logic [47:0] fields);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fields;
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_start(input logic [7:0] op, input logic [15:0] pc,
                              input logic [7:0] x, input logic [7:0] y);
        push_item(MODE_START, {8'($urandom), y, x, pc, op});
    endtask

    // non-data fields carry noise, the block must ignore them
    task automatic send_data(input logic [7:0] b);
        push_item(~MODE_START, {b, 40'($urandom) ^ {8'($urandom), 32'($urandom)}});
    endtask

    task automatic run_lda(input logic [7:0] op, input int unsigned n_data);
        send_start(op, pick_pc(), pick_index(), pick_index());
        repeat (n_data) send_data(8'($urandom));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        int unsigned r;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                n_holds++;
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    m_tready <= 1'b1;
                else if (r < 88)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge clk);
                    m_tready <= 1'b1;
                end
                else if (r < 96)
                begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(negedge clk);
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(negedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lda_addressing_sequencer_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned n;
        logic [7:0]  op;
        logic        hold_done;
        logic        drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stray byte straight after reset
        send_data(8'h5A);
        send_start(8'hFF, 16'h1000, 8'h00, 8'h00);
        // immediate zero, next pc wraps past the top of memory
        send_start(OP_LDA_IMM, 16'hFFFF, 8'h00, 8'hFF);
        send_data(8'h00);
        send_start(OP_LDA_ZP, 16'h0000, 8'hFF, 8'h00);
        send_data(8'hFF);
        send_data(8'h7F);
        // zp,X sum wraps within page zero, negative value
        send_start(OP_LDA_ZPX, 16'h1234, 8'hF0, 8'h00);
        send_data(8'h20);
        send_data(8'h80);
        // abs,X with page cross and operand fetch wrapping to 0000
        send_start(OP_LDA_ABSX, 16'hFFFF, 8'h01, 8'h00);
        send_data(8'hFF);
        send_data(8'h12);
        send_data(8'hC3);
        // (zp,X) pointer at ff, high byte fetched from 00
        send_start(OP_LDA_INDX, 16'h8000, 8'h01, 8'h00);
        send_data(8'hFE);
        send_data(8'h34);
        send_data(8'h12);
        send_data(8'h01);
        // (zp),Y with page cross
        send_start(OP_LDA_INDY, 16'h4000, 8'h00, 8'hFF);
        send_data(8'hFF);
        send_data(8'h80);
        send_data(8'h20);
        send_data(8'hFF);
        // new start aborts an absolute load halfway
        send_start(OP_LDA_ABS, 16'h0200, 8'h00, 8'h00);
        send_data(8'h34);
        send_start(OP_LDA_IMM, 16'h0300, 8'h00, 8'h00);
        send_data(8'h01);

        while (items_sent < ITEM_TARGET)
        begin
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= DRAIN_AT)
            begin
                drain_results();
                drain_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                op = pick_lda_op();
                run_lda(op, data_bytes(op));
                n_loads++;
            end
            else if (r < 87)
            begin
                op = 8'($urandom);
                if (data_bytes(op) != 0)
                    op = op ^ 8'h01;
                send_start(op, pick_pc(), pick_index(), pick_index());
                n_bad_op++;
            end
            else if (r < 93)
            begin
                send_data(8'($urandom));
                n_stray++;
            end
            else
            begin
                op = pick_lda_op();
                n  = $urandom_range(0, data_bytes(op) - 1);
                run_lda(op, n);
                n_aborted++;
            end
        end

        drain_results();
        repeat (10) @(negedge clk);
        $display("covered %0d items: %0d full loads over all eight modes, %0d cut short,",
                 items_sent, n_loads, n_aborted);
        $display("%0d bad opcodes, %0d stray bytes, %0d long output hold-offs",
                 n_bad_op, n_stray, n_holds);
        if (errors == 0)
            $display("lda_addressing_sequencer_core test passed");
        else
            $display("lda_addressing_sequencer_core test failed");
        $finish;
    end

endmodule
